// ===== hw/rtl/stle_pkg.sv =====
// shared types and constants for the session table with idle expiry
// no dependencies; imported by every module of the block
package stle_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int ID_W          = 64;
  localparam int TIME_W        = 32;
  localparam int SLOT_FIELD_W  = 4;
  localparam int COUNT_FIELD_W = 5;

  localparam logic [TIME_W-1:0] IDLE_LIMIT_RESET = TIME_W'(30);

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_CREATE  = 2'd1,
    KIND_DESTROY = 2'd2,
    KIND_SWEEP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   session_id;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     evicted;
    logic [ID_W-1:0]          evicted_id;
    logic [COUNT_FIELD_W-1:0] swept_count;
    logic                     error;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/stle_slot_mem.sv =====
// slot store: one-port-write, one-port-read memory with registered read data
// per-entry valid flags give the all-free reset state; uses stle_pkg
module stle_slot_mem
  import stle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mem_req_t    req,
  output slot_entry_t rd_data
);

  slot_entry_t       mem [SLOTS];
  logic [SLOTS-1:0]  valid;
  slot_entry_t       rd_raw;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_raw <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_valid <= valid[req.rd_addr];
    end
  end

  // entry never written reads as a free slot
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// ===== hw/rtl/stle_ctrl.sv =====
// sequencer: scans the slot store one entry per cycle and writes back changes
// uses stle_pkg; drives stle_slot_mem through a mem_req_t
module stle_ctrl
  import stle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_item_t          item,
  input  logic [TIME_W-1:0] idle_limit,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output out_item_t         res,
  output mem_req_t          req,
  input  slot_entry_t       rd_data
);

  ctrl_state_t       state, state_next;
  logic [SLOT_W-1:0] idx, idx_next;
  in_item_t          op, op_next;
  logic [SLOT_W-1:0] oldest_idx, oldest_idx_next;
  logic [TIME_W-1:0] oldest_age, oldest_age_next;
  logic [ID_W-1:0]   oldest_id, oldest_id_next;
  logic [CNT_W-1:0]  count, count_next;
  out_item_t         res_next;

  logic [TIME_W-1:0] age;
  logic              last;
  logic              used;
  logic              match;
  logic              older;
  logic [CNT_W-1:0]  count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    op         <= op_next;
    oldest_idx <= oldest_idx_next;
    oldest_age <= oldest_age_next;
    oldest_id  <= oldest_id_next;
    count      <= count_next;
    res        <= res_next;
  end

  assign age       = op.now - rd_data.stamp;
  assign last      = (idx == SLOT_W'(SLOTS - 1));
  assign used      = (rd_data.id != '0);
  assign match     = used && (rd_data.id == op.session_id);
  assign older     = (idx == '0) || (age > oldest_age);
  assign count_inc = count + CNT_W'(1);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    op_next         = op;
    oldest_idx_next = oldest_idx;
    oldest_age_next = oldest_age;
    oldest_id_next  = oldest_id;
    count_next      = count;
    res_next        = res;
    req             = '0;
    idle            = 1'b0;
    res_valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        idle        = 1'b1;
        req.rd_addr = '0;
        if (start) begin
          op_next    = item;
          idx_next   = '0;
          count_next = '0;
          res_next   = '0;
          if (item.kind == KIND_CREATE && item.session_id == '0) begin
            res_next.error = 1'b1;
            state_next     = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        req.rd_addr = idx + SLOT_W'(1);
        req.wr_addr = idx;
        idx_next    = idx + SLOT_W'(1);
        unique case (op.kind)
          KIND_LOOKUP: begin
            if (match) begin
              req.we            = 1'b1;
              req.wr_data.id    = rd_data.id;
              req.wr_data.stamp = op.now;
              res_next.hit      = 1'b1;
              res_next.slot     = SLOT_FIELD_W'(idx);
              state_next        = ST_DONE;
            end else if (last) begin
              state_next = ST_DONE;
            end
          end
          KIND_DESTROY: begin
            if (match) begin
              req.we        = 1'b1;
              req.wr_data   = '0;
              res_next.hit  = 1'b1;
              res_next.slot = SLOT_FIELD_W'(idx);
              state_next    = ST_DONE;
            end else if (last) begin
              state_next = ST_DONE;
            end
          end
          KIND_CREATE: begin
            req.wr_data.id    = op.session_id;
            req.wr_data.stamp = op.now;
            if (!used) begin
              req.we        = 1'b1;
              res_next.hit  = 1'b1;
              res_next.slot = SLOT_FIELD_W'(idx);
              state_next    = ST_DONE;
            end else begin
              if (older) begin
                oldest_idx_next = idx;
                oldest_age_next = age;
                oldest_id_next  = rd_data.id;
              end
              if (last) begin
                req.we              = 1'b1;
                req.wr_addr         = older ? idx : oldest_idx;
                res_next.hit        = 1'b1;
                res_next.slot       = SLOT_FIELD_W'(older ? idx : oldest_idx);
                res_next.evicted    = 1'b1;
                res_next.evicted_id = older ? rd_data.id : oldest_id;
                state_next          = ST_DONE;
              end
            end
          end
          KIND_SWEEP: begin
            if (used && age > idle_limit) begin
              req.we      = 1'b1;
              req.wr_data = '0;
              count_next  = count_inc;
            end
            if (last) begin
              res_next.swept_count = COUNT_FIELD_W'(count_next);
              state_next           = ST_DONE;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/session_table_lru_idle_expiry.sv =====
// top level of the session table: idle limit register, output beat register
// instantiates stle_ctrl and stle_slot_mem; uses stle_pkg
//
//   channel  signals                               beat
//   in       in_valid / in_ready / in_data         kind, session_id, now
//   out      out_valid / out_ready / out_data      hit, slot, evicted, evicted_id,
//                                                  swept_count, error
//   cfg      cfg_wr_en / cfg_wr_data               idle_limit, no wait
//
// one request at a time; the slot store is scanned one entry per cycle on its read port
// lookup/destroy end at match, create at free slot, sweep scans all, bad create no scan
// reset clears the slot valid flags at once, so every slot reads free; no clearing pass
// a full output register holds the finished result; input is taken again once it moves on
module session_table_lru_idle_expiry
  import stle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  logic [TIME_W-1:0] idle_limit;
  logic              idle;
  logic              res_valid;
  logic              res_take;
  out_item_t         res;
  mem_req_t          req;
  slot_entry_t       rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      idle_limit <= cfg_wr_data;
    end
  end

  assign in_ready = idle;
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  stle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready),
    .item       (in_data),
    .idle_limit (idle_limit),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .req        (req),
    .rd_data    (rd_data)
  );

  stle_slot_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule
